/* rtl/core/detq_pkg.sv */
// ---------------------------------------------------------------------------
// detq_pkg
// Shared types and codes of the double-ended task queue.
// ---------------------------------------------------------------------------
package detq_pkg;

	localparam int OP_W     = 3;
	localparam int HANDLE_W = 64;
	localparam int STATUS_W = 2;

	// Input tdata: op then handle, padded to whole bytes.
	localparam int IN_FIELDS_W = OP_W + HANDLE_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_POP_MATCH  = 3'd4;

	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_EMPTY    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_MISMATCH = 2'd3;

endpackage

/* rtl/core/double_ended_task_queue_top.sv */
// ---------------------------------------------------------------------------
// double_ended_task_queue_top
// Bounded double-ended queue of 64-bit task handles in a ring of DEPTH slots.
//
// Each input transfer carries one operation (push front, push back, pop front,
// pop back, or pop front only when the front handle matches) and produces
// exactly one output transfer with the popped handle, a status code and the
// fill level after the operation. The slots live in a synchronous memory that
// is read when an operation is taken: the slot it may remove is read into a
// register. The operation completes once the output register is free or being
// emptied; then the pointers are updated, a push is written and the result is
// loaded into the output register. A new operation is accepted while a
// finished result still waits to be taken. Slots hold no reset value; a slot
// without a live entry may be read, but its data never reaches a result.
// ---------------------------------------------------------------------------
module double_ended_task_queue_top #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OUT_FIELDS_W = detq_pkg::HANDLE_W + detq_pkg::STATUS_W + CW,
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0 up: op (3), handle (64), zero padding.
	input  logic [detq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0 up: popped (64), status (2), fill_after (CW), zero padding.
	output logic [OUT_TDATA_W-1:0]            m_axis_tdata
);

	localparam int SW = CW + 1;

	detq_pkg::handle_t mem [DEPTH];

	logic                 busy_q;
	logic [AW-1:0]        front_q;
	logic [CW-1:0]        fill_q;
	detq_pkg::op_t        op_s1;
	detq_pkg::handle_t    handle_s1;
	detq_pkg::handle_t    rdata_s1;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	detq_pkg::op_t        in_op;
	detq_pkg::handle_t    in_handle;
	logic                 in_fire;
	logic                 commit;
	logic                 is_empty;
	logic                 is_full;
	logic [AW-1:0]        front_dec;
	logic [AW-1:0]        front_inc;
	logic [SW-1:0]        sum_push;
	logic [SW-1:0]        sum_last;
	logic [AW-1:0]        back_push;
	logic [AW-1:0]        back_last;
	logic [AW-1:0]        raddr;

	detq_pkg::handle_t    res_popped;
	detq_pkg::status_t    res_status;
	logic [AW-1:0]        front_nxt;
	logic [CW-1:0]        fill_nxt;
	logic                 wr_en;
	logic [AW-1:0]        waddr;

	assign in_op     = s_axis_tdata[detq_pkg::OP_W-1:0];
	assign in_handle = s_axis_tdata[detq_pkg::IN_FIELDS_W-1:detq_pkg::OP_W];

	assign s_axis_tready = !busy_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign commit        = busy_q && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Ring index arithmetic. Offsets stay below twice DEPTH, so one
	// compare and subtract wraps them.
	always_comb begin
		is_empty  = (fill_q == '0);
		is_full   = (fill_q == CW'(DEPTH));
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
		sum_push  = SW'(front_q) + SW'(fill_q);
		sum_last  = sum_push - SW'(1);
		back_push = (sum_push >= SW'(DEPTH)) ? AW'(sum_push - SW'(DEPTH)) : AW'(sum_push);
		back_last = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
		raddr     = (in_op == detq_pkg::OP_POP_BACK && !is_empty) ? back_last : front_q;
	end

	always_comb begin
		res_popped = '0;
		res_status = detq_pkg::ST_DONE;
		front_nxt  = front_q;
		fill_nxt   = fill_q;
		wr_en      = 1'b0;
		waddr      = front_dec;
		case (op_s1)
			detq_pkg::OP_PUSH_FRONT: begin
				if (is_full) begin
					res_status = detq_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					waddr     = front_dec;
					front_nxt = front_dec;
					fill_nxt  = fill_q + CW'(1);
				end
			end
			detq_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					res_status = detq_pkg::ST_FULL;
				end else begin
					wr_en    = 1'b1;
					waddr    = back_push;
					fill_nxt = fill_q + CW'(1);
				end
			end
			detq_pkg::OP_POP_FRONT: begin
				if (is_empty) begin
					res_status = detq_pkg::ST_EMPTY;
				end else begin
					res_popped = rdata_s1;
					front_nxt  = front_inc;
					fill_nxt   = fill_q - CW'(1);
				end
			end
			detq_pkg::OP_POP_BACK: begin
				if (is_empty) begin
					res_status = detq_pkg::ST_EMPTY;
				end else begin
					res_popped = rdata_s1;
					fill_nxt   = fill_q - CW'(1);
				end
			end
			detq_pkg::OP_POP_MATCH: begin
				if (is_empty) begin
					res_status = detq_pkg::ST_EMPTY;
				end else if (rdata_s1 != handle_s1) begin
					res_status = detq_pkg::ST_MISMATCH;
				end else begin
					res_popped = rdata_s1;
					front_nxt  = front_inc;
					fill_nxt   = fill_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Reads happen only on accept and writes only on commit, and the two
	// never share a cycle, so a read always sees every earlier push.
	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			mem[waddr] <= handle_s1;
		end
		if (in_fire) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= in_op;
			handle_s1 <= in_handle;
		end
		if (commit) begin
			out_data_q <= OUT_TDATA_W'({fill_nxt, res_status, res_popped});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			front_q     <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				front_q     <= front_nxt;
				fill_q      <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/detq_checker.sv */
// ---------------------------------------------------------------------------
// detq_checker
// Port-level checks of the double-ended task queue, bound to the top level.
// ---------------------------------------------------------------------------
module detq_checker #(
	parameter int DEPTH = 64,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OUT_FIELDS_W = detq_pkg::HANDLE_W + detq_pkg::STATUS_W + CW,
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [detq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [OUT_TDATA_W-1:0]          m_axis_tdata
);

	localparam int ST_LO = detq_pkg::HANDLE_W;
	localparam int FL_LO = detq_pkg::HANDLE_W + detq_pkg::STATUS_W;

	detq_pkg::handle_t popped;
	detq_pkg::status_t status;
	logic [CW-1:0]     fill_after;

	assign popped     = m_axis_tdata[detq_pkg::HANDLE_W-1:0];
	assign status     = m_axis_tdata[FL_LO-1:ST_LO];
	assign fill_after = m_axis_tdata[OUT_FIELDS_W-1:FL_LO];

	// A refused push only happens with every slot taken.
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == detq_pkg::ST_FULL |-> fill_after == CW'(DEPTH))
		else $error("full status with free slots");

	// An empty pop removes nothing and leaves the queue empty.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == detq_pkg::ST_EMPTY |-> fill_after == '0 && popped == '0)
		else $error("empty status with entries or data");

	// A mismatched conditional pop removes nothing.
	a_mismatch_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == detq_pkg::ST_MISMATCH |-> popped == '0)
		else $error("mismatch status with popped data");

	// Operations are taken one at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transfer accepted while busy");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind double_ended_task_queue_top detq_checker #(.DEPTH(DEPTH)) u_detq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
